// ===== src/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants for the servo pan tracker
// Field widths, register map, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

	// field widths
	localparam int X_W      = 12;   // pixel position / frame width
	localparam int ALPHA_W  = 9;    // Q1.8 EMA weight
	localparam int ANGLE_W  = 16;   // Q8.8 degrees
	localparam int DUTY_W   = 14;   // PWM duty count
	localparam int POS_W    = 20;   // Q12.8 smoothed position
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// serial divider geometry
	localparam int DIV_NUM_W = 30;  // dividend / quotient shift register
	localparam int DIV_DEN_W = 16;  // divisor and remainder
	localparam int CNT_W     = 5;

	// angle scale
	localparam logic [ANGLE_W-1:0] ANGLE_FULL = 16'd46080;  // 180 degrees
	localparam logic [ANGLE_W-1:0] ANGLE_HALF = 16'd23040;  // 90 degrees
	localparam logic [7:0]         DEG_SPAN   = 8'd180;

	// 46080 = 45 * 1024: ceil(2^26 / 45), exact for dividends below 2^20
	localparam logic [20:0] ANGLE_FULL_RCP = 21'd1491309;

	// iteration count (loaded as count - 1)
	localparam logic [CNT_W-1:0] ANG_ITERS  = 5'd27;  // 28-bit dividend

	// register reset values
	localparam logic [X_W-1:0]     SCENE_W_RST   = 12'd640;
	localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd77;
	localparam logic [ANGLE_W-1:0] DEADBAND_RST  = 16'd512;
	localparam logic [DUTY_W-1:0]  DUTY_ZERO_RST = 14'd409;
	localparam logic [DUTY_W-1:0]  DUTY_FULL_RST = 14'd2047;
	localparam logic [POS_W-1:0]   SMOOTHED_RST  = 20'd81920;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;

	// register indexes (word address)
	localparam logic [2:0] REG_SCENE_W     = 3'd0;
	localparam logic [2:0] REG_ALPHA       = 3'd1;
	localparam logic [2:0] REG_DEADBAND    = 3'd2;
	localparam logic [2:0] REG_DUTY_ZERO   = 3'd3;
	localparam logic [2:0] REG_DUTY_FULL   = 3'd4;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CENTRE,
		ST_EMA_MUL,
		ST_EMA_ADD,
		ST_ANG_LOAD,
		ST_ANG_DIV,
		ST_ANG_CHK,
		ST_DUTY_MUL,
		ST_DUTY_LOAD,
		ST_DUTY_DIV,
		ST_DUTY_FIX,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== src/servo_pan_tracker_core.sv =====
// ----------------------------------------------------------------------------
// servo_pan_tracker_core: EMA-smoothed pan servo with deadband
// Smooths a tracked pixel position, maps it to a pan angle and emits a PWM
// duty whenever the angle moves by at least the deadband, and on every recenter.
// ----------------------------------------------------------------------------
// An update beat is taken in the idle state. When it moves the servo, it runs
// through the EMA, angle divide, deadband check and duty states to the emit
// state; an update that the deadband suppresses returns to idle from the
// deadband check. A recenter beat goes from the centre state to the emit
// state. The angle comes from one bit-serial restoring divider for
// smoothed*180/frame width (28 iterations); the duty interpolation divides by
// 46080 with a shift and a reciprocal multiply. item_stall stays high while a
// beat is being worked on; a finished result waits in the output register and
// the next item is taken meanwhile, but a second result holds the sequencer
// until the first has gone. The user must write registers over the APB port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module servo_pan_tracker_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             item_valid,
	output      logic                             item_stall,
	input  wire logic                             operation,
	input  wire logic [spt_pkg::X_W-1:0]          pos_x,
	// result channel
	output      logic                             result_valid,
	input  wire logic                             result_stall,
	output      logic [spt_pkg::DUTY_W-1:0]       duty,
	output      logic [spt_pkg::ANGLE_W-1:0]      angle,
	// configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [spt_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [spt_pkg::PDATA_W-1:0]      pwdata,
	output      logic [spt_pkg::PDATA_W-1:0]      prdata,
	output      logic                             pready
);
	import spt_pkg::*;

	// configuration registers
	logic [X_W-1:0]     scene_w_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [ANGLE_W-1:0] deadband_q;
	logic [DUTY_W-1:0]  duty_zero_q;
	logic [DUTY_W-1:0]  duty_full_q;

	// filter state
	logic [POS_W-1:0]   smoothed_q;
	logic [ANGLE_W-1:0] last_angle_q;

	// sequencer and datapath
	state_t                   state_q, state_d;
	logic [X_W-1:0]           x_q;
	logic signed [30:0]       mul_q;
	logic                     neg_q;
	logic [DIV_NUM_W-1:0]     quo_q;
	logic [DIV_DEN_W-1:0]     rem_q;
	logic [DIV_DEN_W-1:0]     den_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [40:0]              rcp_q;
	logic [ANGLE_W-1:0]       angle_res_q;
	logic [DUTY_W-1:0]        duty_res_q;
	logic                     result_valid_q;
	logic [DUTY_W-1:0]        duty_q;
	logic [ANGLE_W-1:0]       angle_q;

	// control strobes
	logic item_acc;
	logic slot_free;
	logic emit_load;
	logic cfg_wr;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_w_q   <= SCENE_W_RST;
			alpha_q     <= ALPHA_RST;
			deadband_q  <= DEADBAND_RST;
			duty_zero_q <= DUTY_ZERO_RST;
			duty_full_q <= DUTY_FULL_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SCENE_W:     scene_w_q   <= pwdata[X_W-1:0];
				REG_ALPHA:       alpha_q     <= pwdata[ALPHA_W-1:0];
				REG_DEADBAND:    deadband_q  <= pwdata[ANGLE_W-1:0];
				REG_DUTY_ZERO:   duty_zero_q <= pwdata[DUTY_W-1:0];
				REG_DUTY_FULL:   duty_full_q <= pwdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SCENE_W:     prdata = PDATA_W'(scene_w_q);
			REG_ALPHA:       prdata = PDATA_W'(alpha_q);
			REG_DEADBAND:    prdata = PDATA_W'(deadband_q);
			REG_DUTY_ZERO:   prdata = PDATA_W'(duty_zero_q);
			REG_DUTY_FULL:   prdata = PDATA_W'(duty_full_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// effective operands
	// ------------------------------------------------------------------
	logic [X_W-1:0]     fw_eff;
	logic [ALPHA_W-1:0] a_eff;
	logic signed [14:0] span;

	assign fw_eff = (scene_w_q == '0) ? X_W'(1) : scene_w_q;
	assign a_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign span   = $signed({1'b0, duty_full_q}) - $signed({1'b0, duty_zero_q});

	// ------------------------------------------------------------------
	// arithmetic
	// ------------------------------------------------------------------
	// EMA step: a * ((x<<8) - s)
	logic signed [20:0] ema_diff;
	logic signed [30:0] ema_prod;
	assign ema_diff = $signed({1'b0, x_q, 8'd0}) - $signed({1'b0, smoothed_q});
	assign ema_prod = $signed({1'b0, a_eff}) * ema_diff;

	// EMA add: s + ((prod + 128) >>> 8), rounding half up
	logic signed [30:0] ema_rnd;
	logic signed [30:0] ema_sh;
	logic [20:0]        ema_sum;
	assign ema_rnd = mul_q + 31'sd128;
	assign ema_sh  = ema_rnd >>> 8;
	assign ema_sum = {1'b0, smoothed_q} + ema_sh[20:0];

	// angle dividend: s * 180
	logic [27:0] ang_num;
	assign ang_num = 28'(smoothed_q) * 28'(DEG_SPAN);

	// divider step
	logic [DIV_DEN_W:0]   div_trial;
	logic                 div_ge;
	logic [DIV_DEN_W:0]   div_diff;
	assign div_trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign div_ge    = div_trial >= {1'b0, den_q};
	assign div_diff  = div_trial - {1'b0, den_q};

	// angle saturation and deadband test
	logic [ANGLE_W-1:0] ang_sat;
	logic [ANGLE_W-1:0] ang_delta;
	logic               ang_move;
	assign ang_sat   = (quo_q[27:0] > 28'(ANGLE_FULL)) ? ANGLE_FULL : quo_q[ANGLE_W-1:0];
	assign ang_delta = (ang_sat >= last_angle_q) ? ang_sat - last_angle_q
	                                             : last_angle_q - ang_sat;
	assign ang_move  = ang_delta >= deadband_q;

	// duty product: angle * span
	logic signed [31:0] duty_prod;
	logic signed [30:0] duty_neg;
	assign duty_prod = $signed({1'b0, angle_res_q}) * span;
	assign duty_neg  = -mul_q;

	// |product| / 46080: drop 10 bits, then multiply by the reciprocal of 45.
	// An exact multiple of 45 leaves a fraction below the reciprocal itself.
	logic [40:0] rcp_prod;
	logic [14:0] duty_quo;
	logic        duty_inexact;
	assign rcp_prod     = 41'(quo_q[DIV_NUM_W-1:10]) * 41'(ANGLE_FULL_RCP);
	assign duty_quo     = rcp_q[40:26];
	assign duty_inexact = (quo_q[9:0] != '0) || (rcp_q[25:0] >= 26'(ANGLE_FULL_RCP));

	// floored quotient applied to duty_at_zero
	logic [14:0] duty_qm;
	logic [15:0] duty_sum;
	assign duty_qm  = duty_quo + {14'd0, neg_q & duty_inexact};
	assign duty_sum = neg_q ? ({2'b00, duty_zero_q} - {1'b0, duty_qm})
	                        : ({2'b00, duty_zero_q} + {1'b0, duty_qm});

	// recenter duty: zero + floor(span / 2)
	logic signed [14:0] centre_half;
	logic signed [14:0] centre_sum;
	assign centre_half = span >>> 1;
	assign centre_sum  = $signed({1'b0, duty_zero_q}) + centre_half;

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = operation ? ST_CENTRE : ST_EMA_MUL;
			end
			ST_CENTRE:    state_d = ST_EMIT;
			ST_EMA_MUL:   state_d = ST_EMA_ADD;
			ST_EMA_ADD:   state_d = ST_ANG_LOAD;
			ST_ANG_LOAD:  state_d = ST_ANG_DIV;
			ST_ANG_DIV: begin
				if (cnt_q == '0) state_d = ST_ANG_CHK;
			end
			ST_ANG_CHK:   state_d = ang_move ? ST_DUTY_MUL : ST_IDLE;
			ST_DUTY_MUL:  state_d = ST_DUTY_LOAD;
			ST_DUTY_LOAD: state_d = ST_DUTY_DIV;
			ST_DUTY_DIV:  state_d = ST_DUTY_FIX;
			ST_DUTY_FIX:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		item_stall = 1'b1;
		emit_load  = 1'b0;
		case (state_q)
			ST_IDLE: item_stall = 1'b0;
			ST_EMIT: emit_load  = slot_free;
			default: ;
		endcase
	end

	assign item_acc  = item_valid & ~item_stall;
	assign slot_free = ~result_valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// ------------------------------------------------------------------
	// filter state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q   <= SMOOTHED_RST;
			last_angle_q <= ANGLE_HALF;
		end else begin
			case (state_q)
				ST_CENTRE: begin
					smoothed_q   <= {1'b0, fw_eff, 7'd0};
					last_angle_q <= ANGLE_HALF;
				end
				ST_EMA_ADD: smoothed_q <= ema_sum[POS_W-1:0];
				ST_ANG_CHK: begin
					if (ang_move) last_angle_q <= ang_sat;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (item_acc) x_q <= pos_x;
		case (state_q)
			ST_CENTRE: begin
				angle_res_q <= ANGLE_HALF;
				duty_res_q  <= centre_sum[DUTY_W-1:0];
			end
			ST_EMA_MUL: mul_q <= ema_prod;
			ST_ANG_LOAD: begin
				quo_q <= {ang_num, 2'b00};
				rem_q <= '0;
				den_q <= DIV_DEN_W'(fw_eff);
				cnt_q <= ANG_ITERS;
			end
			ST_ANG_DIV: begin
				quo_q <= {quo_q[DIV_NUM_W-2:0], div_ge};
				rem_q <= div_ge ? div_diff[DIV_DEN_W-1:0] : div_trial[DIV_DEN_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_ANG_CHK:  angle_res_q <= ang_sat;
			ST_DUTY_MUL: mul_q <= duty_prod[30:0];
			ST_DUTY_LOAD: begin
				neg_q <= mul_q[30];
				quo_q <= mul_q[30] ? duty_neg[DIV_NUM_W-1:0] : mul_q[DIV_NUM_W-1:0];
			end
			ST_DUTY_DIV: rcp_q <= rcp_prod;
			ST_DUTY_FIX: duty_res_q <= duty_sum[DUTY_W-1:0];
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        result_valid_q <= 1'b0;
		else if (emit_load) result_valid_q <= 1'b1;
		else if (!result_stall) result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			duty_q  <= duty_res_q;
			angle_q <= angle_res_q;
		end
	end

	assign result_valid = result_valid_q;
	assign duty         = duty_q;
	assign angle        = angle_q;

endmodule

`default_nettype wire

// ===== src/spt_checker.sv =====
// ----------------------------------------------------------------------------
// spt_checker: port-level checks for servo_pan_tracker_core
// Watches the item and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        item_valid,
	input wire logic                        item_stall,
	input wire logic                        result_valid,
	input wire logic                        result_stall,
	input wire logic [spt_pkg::DUTY_W-1:0]  duty,
	input wire logic [spt_pkg::ANGLE_W-1:0] angle
);
	import spt_pkg::*;

	// a held result beat stays valid
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// a held result beat keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(duty) && $stable(angle))
		else $error("result payload changed while stalled");

	// one beat at a time: the block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item taken while a beat is in work");

	// commanded angle never beyond 180 degrees
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> angle <= ANGLE_FULL)
		else $error("angle beyond full scale");

endmodule

bind servo_pan_tracker_core spt_checker u_spt_checker (.*);

`default_nettype wire
